// File: src/pcmiwc_pkg.sv
// ----------------------------------------------------------------------------
// pcmiwc_pkg
// Shared types and constants for the PCM integer width converter.
// ----------------------------------------------------------------------------
package pcmiwc_pkg;

	// Sample width codes
	typedef enum logic [1:0] {
		FMT_S8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_S24 = 2'd2,
		FMT_S32 = 2'd3
	} fmt_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SOURCE_FORMAT = 2'd0,
		CFG_DEST_FORMAT   = 2'd1,
		CFG_DITHER_ENABLE = 2'd2
	} cfg_idx_t;

	localparam int SAMPLE_W = 32;
	localparam int RANDOM_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 2;

	// Width of the running sum: sample plus dither plus rounding, with room
	// to see a 32-bit overflow
	localparam int SUM_W = 34;

	// Dither half width: lost bits never exceed 24
	localparam int DITH_W = 24;

endpackage

// File: src/pcmiwc_if.sv
// ----------------------------------------------------------------------------
// pcmiwc_in_if / pcmiwc_out_if
// Valid/ready channels carrying input items and converted result items.
// ----------------------------------------------------------------------------
interface pcmiwc_in_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [pcmiwc_pkg::SAMPLE_W-1:0]    sample_in;
	logic        [pcmiwc_pkg::RANDOM_W-1:0]    random_first;
	logic        [pcmiwc_pkg::RANDOM_W-1:0]    random_second;

	modport source (output valid, sample_in, random_first, random_second, input ready);
	modport sink   (input valid, sample_in, random_first, random_second, output ready);
endinterface

interface pcmiwc_out_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [pcmiwc_pkg::SAMPLE_W-1:0]    sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface

// File: src/pcm_int_width_converter_tpdf.sv
// ----------------------------------------------------------------------------
// pcm_int_width_converter_tpdf
// Converts signed PCM samples between 8, 16, 24 and 32-bit widths, with
// triangular dither, rounding and clamping when narrowing.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the result is computed
//   combinationally from the input register and captured on advance.
// Throughput: one item per cycle unless the result side stalls; both registers
//   advance together whenever the result register is empty or being taken.
// Reset: arst_n clears both valid flags and sets source_format and
//   dest_format to s16 and dither_enable to 1.
module pcm_int_width_converter_tpdf (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pcmiwc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcmiwc_pkg::CFG_DATA_W-1:0]     cfg_data,
	pcmiwc_in_if.sink                             samples,
	pcmiwc_out_if.source                          converted
);

	localparam int SW = pcmiwc_pkg::SUM_W;
	localparam int DW = pcmiwc_pkg::DITH_W;

	// Configuration registers
	pcmiwc_pkg::fmt_t src_fmt_q;
	pcmiwc_pkg::fmt_t dst_fmt_q;
	logic             dither_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q   <= pcmiwc_pkg::FMT_S16;
			dst_fmt_q   <= pcmiwc_pkg::FMT_S16;
			dither_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcmiwc_pkg::CFG_SOURCE_FORMAT: src_fmt_q <= pcmiwc_pkg::fmt_t'(cfg_data);
				pcmiwc_pkg::CFG_DEST_FORMAT:   dst_fmt_q <= pcmiwc_pkg::fmt_t'(cfg_data);
				pcmiwc_pkg::CFG_DITHER_ENABLE: dither_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic valid_s1;
	logic valid_s2;
	logic advance;

	assign advance         = !valid_s2 || converted.ready;
	assign samples.ready   = !valid_s1 || advance;
	assign converted.valid = valid_s2;

	logic signed [pcmiwc_pkg::SAMPLE_W-1:0] sample_s1;
	logic        [pcmiwc_pkg::RANDOM_W-1:0] rnd1_s1;
	logic        [pcmiwc_pkg::RANDOM_W-1:0] rnd2_s1;
	logic signed [pcmiwc_pkg::SAMPLE_W-1:0] sample_s2;
	logic signed [pcmiwc_pkg::SAMPLE_W-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (samples.ready) begin
				valid_s1 <= samples.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture input item and result payloads
	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			sample_s1 <= samples.sample_in;
			rnd1_s1   <= samples.random_first;
			rnd2_s1   <= samples.random_second;
		end
		if (advance && valid_s1) begin
			sample_s2 <= result;
		end
	end

	assign converted.sample_out = sample_s2;

	// Conversion datapath
	logic signed [pcmiwc_pkg::SAMPLE_W-1:0] samp;
	logic        [1:0]                      width_diff;
	logic        [DW-1:0]                   dith_a;
	logic        [DW-1:0]                   dith_b;
	logic signed [DW:0]                     dith;
	logic signed [SW-1:0]                   sum1;
	logic signed [SW-1:0]                   half;
	logic signed [SW-1:0]                   sum2;
	logic signed [SW-1:0]                   shifted;
	logic signed [SW-1:0]                   dmax;
	logic signed [SW-1:0]                   dmin;
	logic                                   src32;
	logic                                   ovf1;
	logic                                   ovf2;

	always_comb begin
		// Sign-extend from the source width
		case (src_fmt_q)
			pcmiwc_pkg::FMT_S8:  samp = 32'(signed'(sample_s1[7:0]));
			pcmiwc_pkg::FMT_S16: samp = 32'(signed'(sample_s1[15:0]));
			pcmiwc_pkg::FMT_S24: samp = 32'(signed'(sample_s1[23:0]));
			default:             samp = sample_s1;
		endcase

		src32 = (src_fmt_q == pcmiwc_pkg::FMT_S32);

		// Width difference in bytes, either direction
		if (dst_fmt_q > src_fmt_q) begin
			width_diff = 2'(dst_fmt_q - src_fmt_q);
		end else begin
			width_diff = 2'(src_fmt_q - dst_fmt_q);
		end

		// Dither halves for the lost bits
		case (width_diff)
			2'd1: begin
				dith_a = DW'(rnd1_s1[7:0]);
				dith_b = DW'(rnd1_s1[15:8]);
				half   = SW'(1) <<< 7;
			end
			2'd2: begin
				dith_a = DW'(rnd1_s1[15:0]);
				dith_b = DW'(rnd1_s1[31:16]);
				half   = SW'(1) <<< 15;
			end
			default: begin
				dith_a = rnd1_s1[DW-1:0];
				dith_b = rnd2_s1[DW-1:0];
				half   = SW'(1) <<< 23;
			end
		endcase

		if (dither_en_q) begin
			dith = $signed({1'b0, dith_a}) - $signed({1'b0, dith_b});
		end else begin
			dith = '0;
		end

		// Add dither, then rounding offset
		sum1 = SW'(samp) + SW'(dith);
		ovf1 = src32 && !((sum1[SW-1:31] == '0) || (sum1[SW-1:31] == '1));
		sum2 = sum1 + half - SW'({1'b0, sum1[SW-1]});
		ovf2 = src32 && !((sum2[SW-1:31] == '0) || (sum2[SW-1:31] == '1));

		case (width_diff)
			2'd1:    shifted = sum2 >>> 8;
			2'd2:    shifted = sum2 >>> 16;
			default: shifted = sum2 >>> 24;
		endcase

		// Destination limits
		case (dst_fmt_q)
			pcmiwc_pkg::FMT_S8: begin
				dmax = SW'(127);
				dmin = -SW'(128);
			end
			pcmiwc_pkg::FMT_S16: begin
				dmax = SW'(32767);
				dmin = -SW'(32768);
			end
			pcmiwc_pkg::FMT_S24: begin
				dmax = SW'(8388607);
				dmin = -SW'(8388608);
			end
			default: begin
				dmax = SW'(32'h7FFF_FFFF);
				dmin = -SW'(33'h0_8000_0000);
			end
		endcase

		// Select widen, pass or narrow
		if (dst_fmt_q > src_fmt_q) begin
			case (width_diff)
				2'd1:    result = samp <<< 8;
				2'd2:    result = samp <<< 16;
				default: result = samp <<< 24;
			endcase
		end else if (dst_fmt_q == src_fmt_q) begin
			result = samp;
		end else if (ovf1) begin
			result = samp[31] ? dmin[31:0] : dmax[31:0];
		end else if (ovf2) begin
			result = sum1[SW-1] ? dmin[31:0] : dmax[31:0];
		end else if (shifted > dmax) begin
			result = dmax[31:0];
		end else if (shifted < dmin) begin
			result = dmin[31:0];
		end else begin
			result = shifted[31:0];
		end
	end

endmodule

// File: tb/pcm_int_width_converter_tpdf_tb.sv
// ----------------------------------------------------------------------------
// pcm_int_width_converter_tpdf_tb
// Self-checking bench for the PCM width converter. Steps the block through
// every source/destination width pair with dither on and off. Each accepted
// sample is converted by a local model of the widen, dither, round and clamp
// path and queued. Every converted sample that leaves the block is compared
// with the oldest queued value.
// ----------------------------------------------------------------------------
module pcm_int_width_converter_tpdf_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES          = 40;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int QUIET_PHASES    = 4;
	localparam int DRAIN_LIMIT     = 2000;
	localparam int CYCLE_LIMIT     = 400000;

	// Holds the converter settings and the converted samples still owed
	class sample_scoreboard;
		pcmiwc_pkg::fmt_t src_fmt;
		pcmiwc_pkg::fmt_t dst_fmt;
		bit               dither_on;
		logic [31:0]      expected_samples[$];
		int               errors;

		function new();
			src_fmt   = pcmiwc_pkg::FMT_S16;
			dst_fmt   = pcmiwc_pkg::FMT_S16;
			dither_on = 1'b1;
			errors    = 0;
		endfunction

		static function longint sign_extend(logic [31:0] v, int w);
			longint x;
			x = longint'({32'd0, v}) <<< (64 - w);
			return x >>> (64 - w);
		endfunction

		// Widen by shifting, pass equal widths, narrow with dither and rounding
		static function logic [31:0] convert_sample(pcmiwc_pkg::fmt_t sf,
				pcmiwc_pkg::fmt_t df, bit dith,
				logic [31:0] smp, logic [31:0] r1, logic [31:0] r2);
			int     sw;
			int     dw;
			int     lost;
			longint s;
			longint d;
			longint s1;
			longint s2;
			longint res;
			longint dmax;
			longint dmin;
			longint mask;
			longint other;
			longint top32;
			longint bot32;
			top32 = 64'sh7FFF_FFFF;
			bot32 = -top32 - 1;
			sw = 8 * (int'(sf) + 1);
			dw = 8 * (int'(df) + 1);
			s  = sign_extend(smp, sw);
			if (dw > sw) begin
				res = s <<< (dw - sw);
			end else if (dw == sw) begin
				res = s;
			end else begin
				lost  = sw - dw;
				dmax  = (64'sd1 <<< (dw - 1)) - 1;
				dmin  = -dmax - 1;
				mask  = (64'sd1 <<< lost) - 1;
				other = (lost > 16) ? longint'({32'd0, r2}) : longint'({32'd0, r1} >> lost);
				d     = dith ? ((longint'({32'd0, r1}) & mask) - (other & mask)) : 64'sd0;
				s1    = s + d;
				if (sw == 32 && (s1 > top32 || s1 < bot32)) begin
					res = (s >= 0) ? dmax : dmin;
				end else begin
					s2 = s1 + (64'sd1 <<< (lost - 1)) - ((s1 < 0) ? 64'sd1 : 64'sd0);
					if (sw == 32 && (s2 > top32 || s2 < bot32)) begin
						res = (s1 >= 0) ? dmax : dmin;
					end else begin
						res = s2 >>> lost;
						if (res > dmax) res = dmax;
						if (res < dmin) res = dmin;
					end
				end
			end
			return res[31:0];
		endfunction

		function void set_config(pcmiwc_pkg::fmt_t sf, pcmiwc_pkg::fmt_t df, bit dith);
			src_fmt   = sf;
			dst_fmt   = df;
			dither_on = dith;
		endfunction

		function void note_input(logic [31:0] smp, logic [31:0] r1, logic [31:0] r2);
			expected_samples.push_back(convert_sample(src_fmt, dst_fmt, dither_on, smp, r1, r2));
		endfunction

		task report(string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [31:0] got);
			logic [31:0] want;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample_out %h with no item pending", got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want)
					report($sformatf("sample_out %h, expected %h", got, want));
			end
		endtask

		task report_leftovers();
			if (expected_samples.size() != 0)
				report($sformatf("%0d items never produced a result",
					expected_samples.size()));
			expected_samples.delete();
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [pcmiwc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pcmiwc_pkg::CFG_DATA_W-1:0] cfg_data;

	pcmiwc_in_if  samples_if ();
	pcmiwc_out_if converted_if ();

	pcm_int_width_converter_tpdf DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.converted (converted_if)
	);

	sample_scoreboard sb = new();

	int send_gap_pct = 20;
	int stall_pct    = 20;
	int stall_left   = 0;
	int cycle_count  = 0;

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Stall the result side in bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			converted_if.ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 6);
			converted_if.ready <= 1'b0;
		end else begin
			converted_if.ready <= 1'b1;
		end
	end

	// Compare every converted item that is taken
	always @(posedge clk) begin
		if (arst_n && converted_if.valid && converted_if.ready)
			sb.check_result(converted_if.sample_out);
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("pcm_int_width_converter_tpdf_tb: errors");
			$finish;
		end
	end

	// Present one item, with an optional idle burst first, and wait for accept
	task automatic send_item(logic [31:0] smp, logic [31:0] r1, logic [31:0] r2);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		samples_if.valid         <= 1'b1;
		samples_if.sample_in     <= smp;
		samples_if.random_first  <= r1;
		samples_if.random_second <= r2;
		do @(posedge clk); while (!samples_if.ready);
		sb.note_input(smp, r1, r2);
	endtask

	// Drop valid and let every owed result come out
	task automatic drain();
		int n;
		n = 0;
		samples_if.valid <= 1'b0;
		while (sb.expected_samples.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (3) @(posedge clk);
	endtask

	// Write all three registers on back-to-back cycles while idle
	task automatic configure(pcmiwc_pkg::fmt_t sf, pcmiwc_pkg::fmt_t df, bit dith);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= pcmiwc_pkg::CFG_SOURCE_FORMAT;
		cfg_data  <= sf;
		@(posedge clk);
		cfg_index <= pcmiwc_pkg::CFG_DEST_FORMAT;
		cfg_data  <= df;
		@(posedge clk);
		cfg_index <= pcmiwc_pkg::CFG_DITHER_ENABLE;
		cfg_data  <= {1'b0, dith};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(sf, df, dith);
	endtask

	// Favor full scale and values near it, where dither can overflow or clamp
	function automatic logic [31:0] pick_sample(pcmiwc_pkg::fmt_t sf);
		int     sw;
		int     pick;
		longint hi;
		longint lo;
		longint span;
		longint v;
		sw   = 8 * (int'(sf) + 1);
		hi   = (64'sd1 <<< (sw - 1)) - 1;
		lo   = -hi - 1;
		span = (sw == 32) ? (64'sd1 <<< 24) : (64'sd1 <<< (sw / 2));
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return $urandom;
		else if (pick < 16)
			v = hi;
		else if (pick < 22)
			v = lo;
		else if (pick < 26)
			v = 0;
		else if (pick < 30)
			v = -1;
		else if (pick < 50)
			v = hi - longint'($urandom_range(0, int'(span)));
		else if (pick < 70)
			v = lo + longint'($urandom_range(0, int'(span)));
		else
			v = sample_scoreboard::sign_extend($urandom, sw);
		return v[31:0];
	endfunction

	function automatic logic [31:0] pick_random_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'h0000_0000;
		else if (pick == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Full scale, out-of-range inputs, dither and rounding overflow, clamping
	task automatic run_directed();
		// reset settings: s16 pass-through
		send_item(32'h0000_7FFF, 32'h0, 32'h0);
		send_item(32'hFFFF_8000, 32'h0, 32'h0);
		send_item(32'h1234_5678, 32'h0, 32'h0);
		send_item(32'h0001_8000, 32'h0, 32'h0);

		configure(pcmiwc_pkg::FMT_S32, pcmiwc_pkg::FMT_S8, 1'b1);
		send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_item(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		configure(pcmiwc_pkg::FMT_S32, pcmiwc_pkg::FMT_S16, 1'b1);
		send_item(32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0);
		send_item(32'h8000_0000, 32'hFFFF_0000, 32'h0);
		send_item(32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

		configure(pcmiwc_pkg::FMT_S8, pcmiwc_pkg::FMT_S32, 1'b0);
		send_item(32'h0000_007F, 32'h0, 32'h0);
		send_item(32'h0000_0080, 32'h0, 32'h0);
		send_item(32'hFFFF_FF01, 32'h0, 32'h0);

		configure(pcmiwc_pkg::FMT_S24, pcmiwc_pkg::FMT_S8, 1'b0);
		send_item(32'h007F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'hFF80_0000, 32'hFFFF_FFFF, 32'h0);
		send_item(32'h0000_0080, 32'h0, 32'h0);
		send_item(32'hFFFF_FF80, 32'h0, 32'h0);

		configure(pcmiwc_pkg::FMT_S16, pcmiwc_pkg::FMT_S8, 1'b1);
		send_item(32'h0000_7FFF, 32'hFFFF_FFFF, 32'h0);
		send_item(32'hFFFF_8000, 32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	initial begin
		int               pace[4];
		pcmiwc_pkg::fmt_t sf;
		pcmiwc_pkg::fmt_t df;
		bit               dith;
		pace = '{0, 15, 35, 60};

		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = pcmiwc_pkg::CFG_SOURCE_FORMAT;
		cfg_data                 = '0;
		samples_if.valid         = 1'b0;
		samples_if.sample_in     = '0;
		samples_if.random_first  = '0;
		samples_if.random_second = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Sweep every width pair with dither on and off, then random settings
		for (int p = 0; p < PHASES; p++) begin
			if (p < 32) begin
				sf   = pcmiwc_pkg::fmt_t'(p % 4);
				df   = pcmiwc_pkg::fmt_t'((p / 4) % 4);
				dith = ((p / 16) % 2) != 0;
			end else begin
				sf   = pcmiwc_pkg::fmt_t'($urandom_range(0, 3));
				df   = pcmiwc_pkg::fmt_t'($urandom_range(0, 3));
				dith = 1'($urandom_range(0, 1));
			end
			configure(sf, df, dith);
			if (p >= PHASES - QUIET_PHASES) begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end else begin
				send_gap_pct = pace[$urandom_range(0, 3)];
				stall_pct    = pace[$urandom_range(0, 3)];
			end
			repeat (ITEMS_PER_PHASE)
				send_item(pick_sample(sf), pick_random_word(), pick_random_word());
		end

		drain();
		repeat (10) @(posedge clk);
		sb.report_leftovers();
		if (sb.errors == 0)
			$display("pcm_int_width_converter_tpdf_tb: clean");
		else
			$display("pcm_int_width_converter_tpdf_tb: errors");
		$finish;
	end

endmodule
